// ===== design/slrg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slrg_pkg
// shared constants and the modular reduction for the shuffled lehmer generator
// ----------------------------------------------------------------------------
package slrg_pkg;

    localparam int          DEFAULT_TABLE_DEPTH = 32;
    localparam int          WARMUP_EXTRA        = 8;
    localparam int          SEED_W              = 32;
    localparam int          SAMPLE_W            = 31;
    localparam int          PROD_W              = 46;
    localparam logic [14:0] LCG_MULT            = 15'd16807;
    localparam logic [31:0] LCG_MOD             = 32'd2147483647;
    localparam logic [30:0] CAP_LIMIT           = 31'd2147483389;

    // mersenne reduction of the product, one conditional subtract
    function automatic logic [SAMPLE_W-1:0] lehmer_reduce(input logic [PROD_W-1:0] prod);
        logic [31:0] sum;
        logic [31:0] fixed;
        sum   = {1'b0, prod[30:0]} + {17'b0, prod[PROD_W-1:31]};
        fixed = (sum >= LCG_MOD) ? (sum - LCG_MOD) : sum;
        return fixed[SAMPLE_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== design/slrg_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slrg_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module slrg_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== design/slrg_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slrg_step
// lehmer step: registered multiply by 16807, then reduction mod 2^31-1
// ----------------------------------------------------------------------------
module slrg_step (
    input  wire logic                              clk,
    input  wire logic                              mul_en,
    input  wire logic [slrg_pkg::SEED_W-1:0]       x,
    output logic      [slrg_pkg::SAMPLE_W-1:0]     res
);

    logic [slrg_pkg::PROD_W-1:0] prod_reg;
    logic [slrg_pkg::PROD_W-1:0] prod_next;

    assign prod_next = slrg_pkg::PROD_W'(x) * slrg_pkg::PROD_W'(slrg_pkg::LCG_MULT);

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign res = slrg_pkg::lehmer_reduce(prod_reg);

endmodule
`default_nettype wire

// ===== design/slrg_pick.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// slrg_pick
// table slot chosen by the last output, clamped to the last entry
// ----------------------------------------------------------------------------
module slrg_pick #(
    parameter int TABLE_DEPTH = slrg_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic [slrg_pkg::SAMPLE_W-1:0]   last_pick,
    output logic      [$clog2(TABLE_DEPTH)-1:0]  slot
);

    localparam int          AW       = $clog2(TABLE_DEPTH);
    localparam logic [31:0] PICK_DIV =
        32'(1 + (slrg_pkg::LCG_MOD - 32'd1) / TABLE_DEPTH);

    logic [TABLE_DEPTH:0] ge;

    // thermometer of threshold compares, then one-hot edge select
    always_comb
    begin
        ge[0]           = 1'b1;
        ge[TABLE_DEPTH] = 1'b0;
        for (int k = 1; k < TABLE_DEPTH; k++)
        begin
            ge[k] = ({1'b0, last_pick} >= (32'(k) * PICK_DIV));
        end
        slot = '0;
        for (int k = 0; k < TABLE_DEPTH; k++)
        begin
            slot = slot | ({AW{ge[k] & ~ge[k+1]}} & AW'(k));
        end
    end

endmodule
`default_nettype wire

// ===== design/shuffled_lehmer_random_generator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shuffled_lehmer_random_generator
// park-miller generator with a bays-durham shuffle table held in one ram
// a draw: multiply and table read at the input transfer, reduce next
// the result register loads from ST_DRED once the output is free; a stalled output holds the draw there
// a warm-up runs TABLE_DEPTH+8 steps: one multiply/reduce pair per step
// one item at a time; next input taken while a result still waits on the output
// reset clears the seed and last pick, so the first draw always warms up
// ----------------------------------------------------------------------------
module shuffled_lehmer_random_generator #(
    parameter int TABLE_DEPTH = slrg_pkg::DEFAULT_TABLE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // seed[31:0]
    input  wire logic [0:0]  s_tuser,   // command[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // sample[30:0], zero[31]
    output logic      [0:0]  m_tuser    // capped[0]
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + slrg_pkg::WARMUP_EXTRA);
    localparam int SW = slrg_pkg::SAMPLE_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WMUL = 2'd1;
    localparam logic [1:0] ST_WRED = 2'd2;
    localparam logic [1:0] ST_DRED = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic               dmul_reg, dmul_next;
    logic signed [31:0] seed_reg, seed_next;
    logic [SW-1:0]      last_pick_reg, last_pick_next;
    logic [31:0]        x_reg, x_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               out_valid_reg, out_valid_next;
    logic [SW-1:0]      sample_reg, sample_next;
    logic               capped_reg, capped_next;

    logic               accept;
    logic signed [31:0] eff_seed;
    logic               warm;
    logic [31:0]        warm_x;
    logic [31:0]        mul_x;
    logic               mul_en;
    logic [SW-1:0]      step_res;
    logic [AW-1:0]      slot;
    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr;
    logic [SW-1:0]      ram_wdata, ram_rdata;
    logic               leave;

    assign s_tready = (state_reg == ST_IDLE) && !dmul_reg;
    assign accept   = s_tvalid && s_tready;

    assign eff_seed = s_tuser[0] ? $signed(s_tdata) : seed_reg;
    assign warm     = (eff_seed <= 32'sd0) || (last_pick_reg == '0);
    assign warm_x   = (eff_seed >= 32'sd0) ? 32'd1 : (32'd0 - 32'(eff_seed));

    assign leave = (state_reg == ST_DRED) && (!out_valid_reg || m_tready);

    assign mul_en = accept || dmul_reg || (state_reg == ST_WMUL);
    assign mul_x  = accept ? (warm ? warm_x : 32'(eff_seed)) : x_reg;

    slrg_step u_step (
        .clk    (clk),
        .mul_en (mul_en),
        .x      (mul_x),
        .res    (step_res)
    );

    slrg_pick #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_pick (
        .last_pick (last_pick_reg),
        .slot      (slot)
    );

    assign ram_re    = (accept && !warm) || dmul_reg;
    assign ram_we    = ((state_reg == ST_WRED) && (count_reg < CW'(TABLE_DEPTH))) || leave;
    assign ram_waddr = (state_reg == ST_WRED) ? count_reg[AW-1:0] : slot;
    assign ram_wdata = step_res;

    slrg_ram #(
        .WIDTH (SW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (slot),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        dmul_next      = 1'b0;
        seed_next      = seed_reg;
        last_pick_next = last_pick_reg;
        x_next         = x_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !m_tready;
        sample_next    = sample_reg;
        capped_next    = capped_reg;

        if (dmul_reg)
        begin
            state_next = ST_DRED;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        seed_next = eff_seed;
                        if (warm)
                        begin
                            count_next = CW'(TABLE_DEPTH + slrg_pkg::WARMUP_EXTRA - 1);
                            state_next = ST_WRED;
                        end
                        else
                        begin
                            state_next = ST_DRED;
                        end
                    end
                end
                ST_WMUL:
                begin
                    state_next = ST_WRED;
                end
                ST_WRED:
                begin
                    x_next = {1'b0, step_res};
                    if (count_reg == '0)
                    begin
                        last_pick_next = step_res;
                        dmul_next      = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                        state_next = ST_WMUL;
                    end
                end
                ST_DRED:
                begin
                    if (leave)
                    begin
                        seed_next      = $signed({1'b0, step_res});
                        last_pick_next = ram_rdata;
                        out_valid_next = 1'b1;
                        sample_next    = ram_rdata;
                        capped_next    = (ram_rdata > slrg_pkg::CAP_LIMIT);
                        state_next     = ST_IDLE;
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dmul_reg      <= 1'b0;
            seed_reg      <= '0;
            last_pick_reg <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dmul_reg      <= dmul_next;
            seed_reg      <= seed_next;
            last_pick_reg <= last_pick_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        sample_reg <= sample_next;
        capped_reg <= capped_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, sample_reg};
    assign m_tuser  = capped_reg;

endmodule
`default_nettype wire
